FILE: hdl/rdk_pkg.sv
// Shared constants, control struct and output saturation for the
// reassignment derivative kernel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rdk_pkg;
	localparam int OUT_W = 32;
	localparam int QBITS = 32;
	localparam int EPS_W = 48;
	localparam int LANES = 6;
	localparam int SUM_W = 66;

	// lane order of the three complex quotients
	localparam int LN_DH_RE  = 0;
	localparam int LN_DH_IM  = 1;
	localparam int LN_TH_RE  = 2;
	localparam int LN_TH_IM  = 3;
	localparam int LN_TDH_RE = 4;
	localparam int LN_TDH_IM = 5;

	typedef struct packed {
		logic vld;
		logic sup;
	} ctl_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (v[SUM_W-1:OUT_W-1] == '0) || (v[SUM_W-1:OUT_W-1] == '1);
		if (fits) begin
			return v[OUT_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
	endfunction
endpackage
`default_nettype wire

FILE: hdl/reassignment_derivative_kernel_top.sv
// Top level of the reassignment derivative kernel: threshold register,
// front end, 32-step divider pipeline, back end. Uses rdk_pkg and submodules.
//
// Usage:
//  Input channel (in_valid / in_stall): one FFT bin per transfer, the
//  real and imaginary parts of X, Dh, Th and TDh, IN_WIDTH bits each.
//  Output channel (out_valid / out_stall): six Q(31-F).F derivatives and
//  the suppressed flag per transfer, one result per input bin, in order.
//  cfg_we / cfg_wdata write eps_threshold_sq; write only while idle.
//  Pipeline: 3 front-end stages, 32 divider stages (one quotient bit per
//  stage) and 3 back-end stages between input transfer and out_valid.
//  Throughput: one bin per cycle while out_stall is low, set by the fully
//  pipelined divider chain.
//  Stall: each stage holds only when it is full and the next one holds,
//  so bubbles squeeze out and in_stall rises only when the whole pipe is
//  full behind a stalled output. Nothing is lost or repeated.
//  Reset (arst_n low): all valid bits clear, threshold returns to 0.
`timescale 1ns / 1ps
`default_nettype none
module reassignment_derivative_kernel_top import rdk_pkg::*; #(
	parameter int IN_WIDTH      = 24,
	parameter int OUT_FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [EPS_W-1:0]           cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [IN_WIDTH-1:0] x_re,
	input  wire logic signed [IN_WIDTH-1:0] x_im,
	input  wire logic signed [IN_WIDTH-1:0] dh_re,
	input  wire logic signed [IN_WIDTH-1:0] dh_im,
	input  wire logic signed [IN_WIDTH-1:0] th_re,
	input  wire logic signed [IN_WIDTH-1:0] th_im,
	input  wire logic signed [IN_WIDTH-1:0] tdh_re,
	input  wire logic signed [IN_WIDTH-1:0] tdh_im,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [OUT_W-1:0]         d_logmag_dt,
	output logic signed [OUT_W-1:0]         d_phase_dt,
	output logic signed [OUT_W-1:0]         d_logmag_dw,
	output logic signed [OUT_W-1:0]         d_phase_dw,
	output logic signed [OUT_W-1:0]         d2_logmag_dtdw,
	output logic signed [OUT_W-1:0]         d2_phase_dtdw,
	output logic                            suppressed
);
	localparam int W  = IN_WIDTH;
	localparam int RW = 2 * W + QBITS;

	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// divider chain links: index 0 is the front-end output
	ctl_t             ctl_c [QBITS+1];
	logic             rdy_c [QBITS+1];
	logic [2*W-1:0]   n_c   [QBITS+1];
	logic [RW-1:0]    rem_c [QBITS+1][LANES];
	logic [QBITS-1:0] q_c   [QBITS+1][LANES];
	logic             neg_c [QBITS+1][LANES];
	logic             ovf_c [QBITS+1][LANES];
	logic             front_rdy;
	ctl_t             ctl_out;

	assign in_stall = !front_rdy;

	rdk_front #(.W(W), .F(OUT_FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (in_valid),
		.rdy_o  (front_rdy),
		.rdy_i  (rdy_c[0]),
		.eps    (eps_q),
		.x_re   (x_re),
		.x_im   (x_im),
		.dh_re  (dh_re),
		.dh_im  (dh_im),
		.th_re  (th_re),
		.th_im  (th_im),
		.tdh_re (tdh_re),
		.tdh_im (tdh_im),
		.ctl_o  (ctl_c[0]),
		.n_o    (n_c[0]),
		.rem_o  (rem_c[0]),
		.neg_o  (neg_c[0]),
		.ovf_o  (ovf_c[0])
	);

	// quotient starts empty; each step sets one bit, MSB first
	always_comb begin
		for (int l = 0; l < LANES; l++) q_c[0][l] = '0;
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_div
		rdk_div_step #(.W(W), .BIT(QBITS - 1 - i)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[i]),
			.rdy_o  (rdy_c[i]),
			.rdy_i  (rdy_c[i+1]),
			.n_i    (n_c[i]),
			.rem_i  (rem_c[i]),
			.q_i    (q_c[i]),
			.neg_i  (neg_c[i]),
			.ovf_i  (ovf_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.n_o    (n_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.q_o    (q_c[i+1]),
			.neg_o  (neg_c[i+1]),
			.ovf_o  (ovf_c[i+1])
		);
	end

	rdk_back #(.F(OUT_FRAC_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_i          (ctl_c[QBITS]),
		.rdy_o          (rdy_c[QBITS]),
		.rdy_i          (!out_stall),
		.q_i            (q_c[QBITS]),
		.neg_i          (neg_c[QBITS]),
		.ovf_i          (ovf_c[QBITS]),
		.ctl_o          (ctl_out),
		.d_logmag_dt    (d_logmag_dt),
		.d_phase_dt     (d_phase_dt),
		.d_logmag_dw    (d_logmag_dw),
		.d_phase_dw     (d_phase_dw),
		.d2_logmag_dtdw (d2_logmag_dtdw),
		.d2_phase_dtdw  (d2_phase_dtdw)
	);

	assign out_valid  = ctl_out.vld;
	assign suppressed = ctl_out.sup;

	// a suppressed bin carries all-zero derivatives
	a_sup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && suppressed |-> d_logmag_dt == '0 && d_phase_dt == '0 &&
			d_logmag_dw == '0 && d_phase_dw == '0 && d2_logmag_dtdw == '0 &&
			d2_phase_dtdw == '0)
		else $error("suppressed bin with nonzero output");

	// input back-pressure only when the whole pipe is full behind a held output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// saturated negation never yields the most negative value
	a_neg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> d_logmag_dw != {1'b1, {(OUT_W-1){1'b0}}})
		else $error("d_logmag_dw negation not saturated");
endmodule
`default_nettype wire

FILE: hdl/rdk_front.sv
// Front end: cross products, |X|^2, numerator sign/magnitude, threshold
// and quotient overflow check. Three stages. Uses rdk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdk_front import rdk_pkg::*; #(
	parameter int W = 24,
	parameter int F = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                vld_i,
	output logic                     rdy_o,
	input  wire logic                rdy_i,
	input  wire logic [EPS_W-1:0]    eps,
	input  wire logic signed [W-1:0] x_re,
	input  wire logic signed [W-1:0] x_im,
	input  wire logic signed [W-1:0] dh_re,
	input  wire logic signed [W-1:0] dh_im,
	input  wire logic signed [W-1:0] th_re,
	input  wire logic signed [W-1:0] th_im,
	input  wire logic signed [W-1:0] tdh_re,
	input  wire logic signed [W-1:0] tdh_im,
	output ctl_t                     ctl_o,
	output logic [2*W-1:0]           n_o,
	output logic [2*W+QBITS-1:0]     rem_o [LANES],
	output logic                     neg_o [LANES],
	output logic                     ovf_o [LANES]
);
	localparam int PW   = 2 * W;
	localparam int RW   = 2 * W + QBITS;
	localparam int CMPW = (PW > EPS_W) ? PW : EPS_W;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [PW-1:0] xx_s1, yy_s1;
	logic signed [PW-1:0] pa_s1 [LANES];
	logic signed [PW-1:0] pb_s1 [LANES];
	logic [PW-1:0]        n_s2;
	logic [PW-1:0]        mag_s2 [LANES];
	logic                 neg_s2 [LANES];
	logic [PW-1:0]        n_s3;
	logic [RW-1:0]        rem_s3 [LANES];
	logic                 neg_s3 [LANES];
	logic                 ovf_s3 [LANES];

	logic signed [W-1:0] ar [LANES];
	logic signed [W-1:0] ai [LANES];

	logic signed [PW:0] num [LANES];
	logic [PW-1:0] n_c;

	assign rdy3  = !ctl_s3.vld || rdy_i;
	assign rdy2  = !ctl_s2.vld || rdy3;
	assign rdy1  = !ctl_s1.vld || rdy2;
	assign rdy_o = rdy1;

	// per lane operand pair: re lanes take (ar*xr, ai*xi), im lanes (ai*xr, ar*xi)
	always_comb begin
		ar[LN_DH_RE]  = dh_re;  ai[LN_DH_RE]  = dh_im;
		ar[LN_DH_IM]  = dh_im;  ai[LN_DH_IM]  = dh_re;
		ar[LN_TH_RE]  = th_re;  ai[LN_TH_RE]  = th_im;
		ar[LN_TH_IM]  = th_im;  ai[LN_TH_IM]  = th_re;
		ar[LN_TDH_RE] = tdh_re; ai[LN_TDH_RE] = tdh_im;
		ar[LN_TDH_IM] = tdh_im; ai[LN_TDH_IM] = tdh_re;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (rdy1) ctl_s1 <= '{vld: vld_i, sup: 1'b0};
			if (rdy2) ctl_s2 <= '{vld: ctl_s1.vld,
				sup: (CMPW'(n_c) <= CMPW'(eps))};
			if (rdy3) ctl_s3 <= ctl_s2;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (rdy1 && vld_i) begin
			xx_s1 <= x_re * x_re;
			yy_s1 <= x_im * x_im;
			for (int l = 0; l < LANES; l++) begin
				pa_s1[l] <= ar[l] * x_re;
				pb_s1[l] <= ai[l] * x_im;
			end
		end
	end

	// stage 2: |X|^2 and numerator sign/magnitude; threshold compare feeds ctl_s2 above
	always_comb begin
		n_c = PW'(xx_s1) + PW'(yy_s1);
		for (int l = 0; l < LANES; l++) begin
			if (l % 2 == 0) num[l] = {pa_s1[l][PW-1], pa_s1[l]} + {pb_s1[l][PW-1], pb_s1[l]};
			else            num[l] = {pa_s1[l][PW-1], pa_s1[l]} - {pb_s1[l][PW-1], pb_s1[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && ctl_s1.vld) begin
			n_s2 <= n_c;
			for (int l = 0; l < LANES; l++) begin
				neg_s2[l] <= num[l][PW];
				mag_s2[l] <= num[l][PW] ? PW'(-num[l]) : PW'(num[l]);
			end
		end
	end

	// stage 3: scaled dividend and integer-part overflow check
	always_ff @(posedge clk) begin
		if (rdy3 && ctl_s2.vld) begin
			n_s3 <= n_s2;
			for (int l = 0; l < LANES; l++) begin
				neg_s3[l] <= neg_s2[l];
				rem_s3[l] <= RW'(mag_s2[l]) << F;
				ovf_s3[l] <= RW'(mag_s2[l]) >= (RW'(n_s2) << (QBITS - F));
			end
		end
	end

	assign ctl_o = ctl_s3;
	assign n_o   = n_s3;
	assign rem_o = rem_s3;
	assign neg_o = neg_s3;
	assign ovf_o = ovf_s3;
endmodule
`default_nettype wire

FILE: hdl/rdk_div_step.sv
// One restoring division step (quotient bit BIT) for all six lanes,
// one register stage. Uses rdk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdk_div_step import rdk_pkg::*; #(
	parameter int W   = 24,
	parameter int BIT = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_t                    ctl_i,
	output logic                         rdy_o,
	input  wire logic                    rdy_i,
	input  wire logic [2*W-1:0]          n_i,
	input  wire logic [2*W+QBITS-1:0]    rem_i [LANES],
	input  wire logic [QBITS-1:0]        q_i [LANES],
	input  wire logic                    neg_i [LANES],
	input  wire logic                    ovf_i [LANES],
	output ctl_t                         ctl_o,
	output logic [2*W-1:0]               n_o,
	output logic [2*W+QBITS-1:0]         rem_o [LANES],
	output logic [QBITS-1:0]             q_o [LANES],
	output logic                         neg_o [LANES],
	output logic                         ovf_o [LANES]
);
	localparam int RW = 2 * W + QBITS;

	ctl_t             ctl_s1;
	logic [2*W-1:0]   n_s1;
	logic [RW-1:0]    rem_s1 [LANES];
	logic [QBITS-1:0] q_s1 [LANES];
	logic             neg_s1 [LANES];
	logic             ovf_s1 [LANES];
	logic [RW-1:0]    dsh;

	assign rdy_o = !ctl_s1.vld || rdy_i;
	assign dsh   = RW'(n_i) << BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_o) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && ctl_i.vld) begin
			n_s1 <= n_i;
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= neg_i[l];
				ovf_s1[l] <= ovf_i[l];
				if (rem_i[l] >= dsh) begin
					rem_s1[l] <= rem_i[l] - dsh;
					q_s1[l]   <= q_i[l] | (QBITS'(1) << BIT);
				end else begin
					rem_s1[l] <= rem_i[l];
					q_s1[l]   <= q_i[l];
				end
			end
		end
	end

	assign ctl_o = ctl_s1;
	assign n_o   = n_s1;
	assign rem_o = rem_s1;
	assign q_o   = q_s1;
	assign neg_o = neg_s1;
	assign ovf_o = ovf_s1;
endmodule
`default_nettype wire

FILE: hdl/rdk_back.sv
// Back end: quotient sign and saturation, Th/X * Dh/X product, final sums
// and the output register. Three stages. Uses rdk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rdk_back import rdk_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ctl_t                    ctl_i,
	output logic                         rdy_o,
	input  wire logic                    rdy_i,
	input  wire logic [QBITS-1:0]        q_i [LANES],
	input  wire logic                    neg_i [LANES],
	input  wire logic                    ovf_i [LANES],
	output ctl_t                         ctl_o,
	output logic signed [OUT_W-1:0]      d_logmag_dt,
	output logic signed [OUT_W-1:0]      d_phase_dt,
	output logic signed [OUT_W-1:0]      d_logmag_dw,
	output logic signed [OUT_W-1:0]      d_phase_dw,
	output logic signed [OUT_W-1:0]      d2_logmag_dtdw,
	output logic signed [OUT_W-1:0]      d2_phase_dtdw
);
	localparam logic signed [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [OUT_W-1:0]   v_s1 [LANES];
	logic signed [OUT_W-1:0]   v_s2 [LANES];
	logic signed [2*OUT_W-1:0] arbr_s2, aibi_s2, arbi_s2, aibr_s2;
	logic signed [OUT_W-1:0]   o_s3 [LANES];

	assign rdy3  = !ctl_s3.vld || rdy_i;
	assign rdy2  = !ctl_s2.vld || rdy3;
	assign rdy1  = !ctl_s1.vld || rdy2;
	assign rdy_o = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (rdy1) ctl_s1 <= ctl_i;
			if (rdy2) ctl_s2 <= ctl_s1;
			if (rdy3) ctl_s3 <= ctl_s2;
		end
	end

	// stage 1: signed, saturated quotients
	always_ff @(posedge clk) begin
		if (rdy1 && ctl_i.vld) begin
			for (int l = 0; l < LANES; l++) begin
				if (ovf_i[l])                          v_s1[l] <= neg_i[l] ? SMIN : SMAX;
				else if (neg_i[l] && q_i[l] > QBITS'(SMIN)) v_s1[l] <= SMIN;
				else if (neg_i[l])                     v_s1[l] <= -$signed(q_i[l]);
				else if (q_i[l][QBITS-1])              v_s1[l] <= SMAX;
				else                                   v_s1[l] <= $signed(q_i[l]);
			end
		end
	end

	// stage 2: A*B partial products (A = Th/X, B = Dh/X)
	always_ff @(posedge clk) begin
		if (rdy2 && ctl_s1.vld) begin
			v_s2    <= v_s1;
			arbr_s2 <= v_s1[LN_TH_RE] * v_s1[LN_DH_RE];
			aibi_s2 <= v_s1[LN_TH_IM] * v_s1[LN_DH_IM];
			arbi_s2 <= v_s1[LN_TH_RE] * v_s1[LN_DH_IM];
			aibr_s2 <= v_s1[LN_TH_IM] * v_s1[LN_DH_RE];
		end
	end

	// stage 3: floor each product by 2^F, sum exactly, saturate
	logic signed [SUM_W-1:0] pr, pi, t4, t5, t2;
	always_comb begin
		pr = SUM_W'(arbr_s2 >>> F) - SUM_W'(aibi_s2 >>> F);
		pi = SUM_W'(arbi_s2 >>> F) + SUM_W'(aibr_s2 >>> F);
		t4 = pi - SUM_W'(v_s2[LN_TDH_IM]);
		t5 = SUM_W'(v_s2[LN_TDH_RE]) - pr;
		t2 = -SUM_W'(v_s2[LN_TH_IM]);
	end

	always_ff @(posedge clk) begin
		if (rdy3 && ctl_s2.vld) begin
			if (ctl_s2.sup) begin
				for (int l = 0; l < LANES; l++) o_s3[l] <= '0;
			end else begin
				o_s3[0] <= v_s2[LN_DH_RE];
				o_s3[1] <= v_s2[LN_DH_IM];
				o_s3[2] <= sat_out(t2);
				o_s3[3] <= v_s2[LN_TH_RE];
				o_s3[4] <= sat_out(t4);
				o_s3[5] <= sat_out(t5);
			end
		end
	end

	assign ctl_o          = ctl_s3;
	assign d_logmag_dt    = o_s3[0];
	assign d_phase_dt     = o_s3[1];
	assign d_logmag_dw    = o_s3[2];
	assign d_phase_dw     = o_s3[3];
	assign d2_logmag_dtdw = o_s3[4];
	assign d2_phase_dtdw  = o_s3[5];
endmodule
`default_nettype wire
